// ===== rtl/message_slot_table_core_defines.svh =====
// Assertion macros shared by the datapath and controller RTL files.
`ifndef MESSAGE_SLOT_TABLE_CORE_DEFINES_SVH
`define MESSAGE_SLOT_TABLE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MST_ASSERT_IMP(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MST_ASSERT_NOW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);
`else
`define MST_ASSERT_IMP(label, clk, rst_n, cond, msg)
`define MST_ASSERT_NOW(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/mst_pkg.sv =====
package mst_pkg;
    localparam int CALL_W = 48;
    localparam int TIME_W = 32;
    localparam int TAG_W = 2;
    localparam int MAX_OUT = 16;

    localparam logic [1:0] TAG_ERASABLE = 2'd0;
    localparam logic [1:0] TAG_UNSENT = 2'd1;
    localparam logic [1:0] TAG_SENT = 2'd2;

    localparam logic [1:0] KIND_SWEEP = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_ASK = 2'd2;
    localparam logic [1:0] KIND_LIST = 2'd3;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_QUOTA = 3'd2;
    localparam logic [2:0] ST_LONG = 3'd3;
    localparam logic [2:0] ST_FOUND = 3'd4;
    localparam logic [2:0] ST_NONE = 3'd5;
    localparam logic [2:0] ST_ENTRY = 3'd6;
    localparam logic [2:0] ST_EMPTY = 3'd7;

    localparam logic [1:0] CFG_SENT_EXP = 2'd0;
    localparam logic [1:0] CFG_UNSENT_EXP = 2'd1;
    localparam logic [1:0] CFG_QUOTA = 2'd2;
    localparam logic [1:0] CFG_MAXLEN = 2'd3;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input word, clear scan accumulators
        logic scan;      // examine slot at the scan index
        logic commit;    // apply the store or ask update
        logic emit;      // present a result word
        logic adv;       // advance the scan index
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic       scan_end;   // scan index is on the last slot
        logic       list_hit;   // slot under scan is live and listable
        logic       list_more;  // a listable live slot lies beyond the scan index
        logic       out_busy;   // output register still holds a word
    } t_stat;
endpackage

// ===== rtl/mst_datapath.sv =====
`include "message_slot_table_core_defines.svh"
module mst_datapath #(
    parameter int SLOTS = 16,
    parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [1:0]           i_kind,
    input  logic [31:0]          i_now,
    input  logic [47:0]          i_who,
    input  logic [47:0]          i_to,
    input  logic [7:0]           i_len,
    input  mst_pkg::t_cmd        i_cmd,
    output mst_pkg::t_stat       o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_status,
    output logic [3:0]           o_slot,
    output logic [1:0]           o_tag,
    output logic [47:0]          o_rcp,
    output logic [47:0]          o_snd,
    output logic [31:0]          o_time,
    output logic                 o_last
);
    import mst_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);

    logic [1:0]  r_tag [SLOTS];
    logic [47:0] r_rcp [SLOTS];
    logic [47:0] r_snd [SLOTS];
    logic [31:0] r_tim [SLOTS];
    logic [CW-1:0] r_live;

    logic [31:0] r_sent_exp, r_unsent_exp;
    logic [4:0]  r_quota;
    logic [7:0]  r_maxlen;

    logic [1:0]  r_kind;
    logic [31:0] r_now;
    logic [47:0] r_who, r_to;
    logic [7:0]  r_len;

    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_held;
    logic          r_free_ok, r_best_ok;
    logic [IW-1:0] r_free, r_best;
    logic [4:0]    r_listed;

    logic       r_ov;
    logic [2:0] r_ost;
    logic [3:0] r_oslot;
    logic [1:0] r_otag;
    logic [47:0] r_orcp, r_osnd;
    logic [31:0] r_otim;
    logic        r_olast;

    logic [1:0]  s_tag;
    logic        s_live, s_expire;
    logic [31:0] s_age;
    logic [SLOTS-1:0] s_live_vec;
    logic        s_more;
    logic        s_full, s_quota, s_long;
    logic [IW-1:0] s_sel;
    logic [2:0]  s_st;
    logic        s_with;

    assign s_tag = r_tag[r_idx];
    assign s_live = (s_tag != TAG_ERASABLE);
    assign s_age = r_now - r_tim[r_idx];
    assign s_expire = s_live &&
        (s_age >= ((s_tag == TAG_SENT) ? r_sent_exp : r_unsent_exp));

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            s_live_vec[k] = (r_tag[k] != TAG_ERASABLE) && (k > int'(r_idx));
        end
        s_more = (|s_live_vec) && ((r_listed + 5'(s_live)) < 5'(MAX_OUT));
    end

    assign o_stat.scan_end = (r_idx == IW'(SLOTS - 1));
    assign o_stat.list_hit = s_live && (r_listed < 5'(MAX_OUT));
    assign o_stat.list_more = s_more;
    assign o_stat.out_busy = r_ov;

    assign s_full = (r_live >= CW'(SLOTS)) || !r_free_ok;
    assign s_quota = ({{(CW > 5 ? CW - 5 : 0){1'b0}}, r_quota} <= (CW > 5 ? CW : 5)'(r_held));
    assign s_long = (r_len > r_maxlen);

    always_comb begin
        s_sel = r_idx;
        s_with = 1'b0;
        s_st = ST_EMPTY;
        case (r_kind)
            KIND_STORE: begin
                s_sel = r_free;
                if (r_live >= CW'(SLOTS)) s_st = ST_FULL;
                else if (s_quota) s_st = ST_QUOTA;
                else if (s_long) s_st = ST_LONG;
                else if (!r_free_ok) s_st = ST_FULL;
                else begin
                    s_st = ST_STORED;
                    s_with = 1'b1;
                end
            end
            KIND_ASK: begin
                s_sel = r_best;
                s_st = r_best_ok ? ST_FOUND : ST_NONE;
                s_with = r_best_ok;
            end
            KIND_LIST: begin
                s_st = s_live ? ST_ENTRY : ST_EMPTY;
                s_with = s_live;
            end
            default: s_st = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_exp <= 32'd86400;
            r_unsent_exp <= 32'd604800;
            r_quota <= 5'd4;
            r_maxlen <= 8'd200;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SENT_EXP: r_sent_exp <= i_cfg_data;
                CFG_UNSENT_EXP: r_unsent_exp <= i_cfg_data;
                CFG_QUOTA: r_quota <= i_cfg_data[4:0];
                CFG_MAXLEN: r_maxlen <= i_cfg_data[7:0];
                default: r_maxlen <= r_maxlen;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_now <= i_now;
            r_who <= i_who;
            r_to <= i_to;
            r_len <= i_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_tag[k] <= TAG_ERASABLE;
                r_rcp[k] <= '0;
                r_snd[k] <= '0;
                r_tim[k] <= '0;
            end
            r_live <= '0;
            r_idx <= '0;
            r_held <= '0;
            r_free_ok <= 1'b0;
            r_best_ok <= 1'b0;
            r_free <= '0;
            r_best <= '0;
            r_listed <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                r_held <= '0;
                r_free_ok <= 1'b0;
                r_best_ok <= 1'b0;
                r_free <= '0;
                r_best <= '0;
                r_listed <= '0;
            end
            if (i_cmd.scan) begin
                case (r_kind)
                    KIND_SWEEP: begin
                        if (s_expire) begin
                            r_tag[r_idx] <= TAG_ERASABLE;
                            r_live <= r_live - CW'(1);
                        end
                    end
                    KIND_STORE: begin
                        if (s_live && r_snd[r_idx] == r_who) r_held <= r_held + CW'(1);
                        if (!s_live && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free <= r_idx;
                        end
                    end
                    KIND_ASK: begin
                        if (s_live && r_rcp[r_idx] == r_who &&
                            (!r_best_ok || r_tim[r_idx] < r_tim[r_best])) begin
                            r_best_ok <= 1'b1;
                            r_best <= r_idx;
                        end
                    end
                    default: r_held <= r_held;
                endcase
            end
            if (i_cmd.commit) begin
                if (r_kind == KIND_STORE && s_st == ST_STORED) begin
                    r_tag[r_free] <= TAG_UNSENT;
                    r_rcp[r_free] <= r_to;
                    r_snd[r_free] <= r_who;
                    r_tim[r_free] <= r_now;
                    r_live <= r_live + CW'(1);
                end else if (r_kind == KIND_ASK && r_best_ok) begin
                    r_tag[r_best] <= TAG_SENT;
                    r_tim[r_best] <= r_now;
                end
            end
            if (i_cmd.emit && r_kind == KIND_LIST && s_live) r_listed <= r_listed + 5'd1;
            if (i_cmd.adv) r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ost <= s_st;
            r_oslot <= s_with ? 4'(s_sel) : 4'd0;
            if (r_kind == KIND_STORE && s_st == ST_STORED) begin
                r_otag <= TAG_UNSENT;
                r_orcp <= r_to;
                r_osnd <= r_who;
                r_otim <= r_now;
            end else begin
                r_otag <= s_with ? r_tag[s_sel] : 2'd0;
                r_orcp <= s_with ? r_rcp[s_sel] : 48'd0;
                r_osnd <= s_with ? r_snd[s_sel] : 48'd0;
                r_otim <= s_with ? r_tim[s_sel] : 32'd0;
            end
            r_olast <= (r_kind != KIND_LIST) || !s_live || !s_more;
        end
    end

    // Store results show the slot after the write.
    assign o_out_valid = r_ov;
    assign o_status = r_ost;
    assign o_slot = r_oslot;
    assign o_tag = r_otag;
    assign o_rcp = r_orcp;
    assign o_snd = r_osnd;
    assign o_time = r_otim;
    assign o_last = r_olast;

    `MST_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, !(i_cmd.emit && r_ov && !i_out_ready), "emit over a held word")
    `MST_ASSERT_IMP(a_live_max, i_clk, i_rst_n, r_live <= CW'(SLOTS), "live count overflow")
    `MST_ASSERT_IMP(a_empty_last, i_clk, i_rst_n, !(r_ov && r_ost == ST_EMPTY && !r_olast), "empty not last")
endmodule

// ===== rtl/mst_ctrl.sv =====
`include "message_slot_table_core_defines.svh"
module mst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_kind,
    input  mst_pkg::t_stat i_stat,
    output mst_pkg::t_cmd  o_cmd
);
    import mst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DONE = 5'b00100,
        S_LIST = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_kind;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_kind == KIND_LIST) ? S_LIST : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.adv = !i_stat.scan_end;
                if (i_stat.scan_end) n_state = (r_kind == KIND_SWEEP) ? S_IDLE : S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_stat.list_hit) begin
                    n_state = S_EMIT;
                end else if (i_stat.list_more) begin
                    o_cmd.adv = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.list_hit && i_stat.list_more) begin
                        o_cmd.adv = 1'b1;
                        n_state = S_LIST;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind <= KIND_SWEEP;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) r_kind <= i_kind;
        end
    end

    `MST_ASSERT_IMP(a_one_hot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `MST_ASSERT_IMP(a_load_idle, i_clk, i_rst_n, !(o_cmd.load && r_state != S_IDLE), "load outside idle")
    `MST_ASSERT_IMP(a_commit_emit, i_clk, i_rst_n, o_cmd.commit == (o_cmd.emit && r_state == S_DONE), "commit without emit")
endmodule

// ===== rtl/message_slot_table_core.sv =====
// Sweep, store and ask examine one slot per cycle across all SLOTS slots; store and ask then
// emit one result word once the output register is free.
// List emits one word per live slot, skipping empty ones, or one empty word if none is live.
// A new command is taken only after the previous command has finished.
// Reset (synchronous, active low) clears all slots to erasable and zero, the live
// count, and restores the register defaults.
module message_slot_table_core #(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[1:0], now_time[33:2], sender_call[81:34], recipient_call[129:82],
    // message_length[137:130], zero fill
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], slot_index[6:3], entry_tag[8:7], entry_recipient[56:9],
    // entry_sender[104:57], entry_time[136:105], zero fill
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import mst_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [2:0]  st;
    logic [3:0]  slot;
    logic [1:0]  tag;
    logic [47:0] rcp, snd;
    logic [31:0] tim;

    mst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_kind(s_axis_tdata[1:0]), .i_stat(stat), .o_cmd(cmd)
    );

    mst_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_kind(s_axis_tdata[1:0]), .i_now(s_axis_tdata[33:2]),
        .i_who(s_axis_tdata[81:34]), .i_to(s_axis_tdata[129:82]),
        .i_len(s_axis_tdata[137:130]),
        .i_cmd(cmd), .o_stat(stat),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_status(st), .o_slot(slot), .o_tag(tag), .o_rcp(rcp), .o_snd(snd),
        .o_time(tim), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, tim, snd, rcp, tag, slot, st};
endmodule

// ===== bench/testbench.sv =====
module testbench;
    import mst_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCH_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [7:0]  length;
        logic [47:0] recipient;
        logic [47:0] sender;
        logic [31:0] now;
        logic [1:0]  kind;
    } t_tb_cmd;

    typedef struct packed {
        logic        last;
        logic [31:0] etime;
        logic [47:0] esender;
        logic [47:0] erecipient;
        logic [1:0]  etag;
        logic [3:0]  slot;
        logic [2:0]  status;
    } t_tb_reply;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tlast;

    message_slot_table_core #(.SLOTS(NSLOT)) dut (.*);

    always #2 i_clk = ~i_clk;

    logic [1:0]  tag_m [NSLOT];
    logic [47:0] rcp_m [NSLOT];
    logic [47:0] snd_m [NSLOT];
    logic [31:0] tim_m [NSLOT];
    int          live_m;
    logic [31:0] sent_exp_m, unsent_exp_m;
    logic [4:0]  quota_m;
    logic [7:0]  maxlen_m;

    t_tb_cmd   pending_cmds[$];
    t_tb_reply expected_replies[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     recv_hold = 0;
    bit     hold_req = 0;
    int     hold_cnt = 0;
    bit     sender_pause = 0;
    int     idle_cycles = 0;

    function automatic t_tb_reply slot_reply(logic [2:0] st, int i, bit lst);
        t_tb_reply r;
        r.status = st;
        r.slot = i[3:0];
        r.etag = tag_m[i];
        r.erecipient = rcp_m[i];
        r.esender = snd_m[i];
        r.etime = tim_m[i];
        r.last = lst;
        return r;
    endfunction

    function automatic t_tb_reply bare_reply(logic [2:0] st);
        t_tb_reply r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_mailbox(t_tb_cmd c);
        int held;
        int best;
        int n;
        logic [31:0] lim;
        held = 0;
        best = -1;
        n = 0;
        case (c.kind)
            KIND_SWEEP: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tag_m[i] != TAG_ERASABLE) begin
                        lim = (tag_m[i] == TAG_SENT) ? sent_exp_m : unsent_exp_m;
                        if (c.now - tim_m[i] >= lim) begin
                            tag_m[i] = TAG_ERASABLE;
                            if (live_m > 0) live_m--;
                        end
                    end
                end
            end
            KIND_STORE: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tag_m[i] != TAG_ERASABLE && snd_m[i] == c.sender) held++;
                if (live_m >= NSLOT) expected_replies.push_back(bare_reply(ST_FULL));
                else if (held >= quota_m) expected_replies.push_back(bare_reply(ST_QUOTA));
                else if (c.length > maxlen_m) expected_replies.push_back(bare_reply(ST_LONG));
                else begin
                    for (int i = 0; i < NSLOT; i++)
                        if (best < 0 && tag_m[i] == TAG_ERASABLE) best = i;
                    if (best < 0) expected_replies.push_back(bare_reply(ST_FULL));
                    else begin
                        tag_m[best] = TAG_UNSENT;
                        rcp_m[best] = c.recipient;
                        snd_m[best] = c.sender;
                        tim_m[best] = c.now;
                        live_m++;
                        expected_replies.push_back(slot_reply(ST_STORED, best, 1'b1));
                    end
                end
            end
            KIND_ASK: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tag_m[i] != TAG_ERASABLE && rcp_m[i] == c.sender)
                        if (best < 0 || tim_m[i] < tim_m[best]) best = i;
                if (best < 0) expected_replies.push_back(bare_reply(ST_NONE));
                else begin
                    expected_replies.push_back(slot_reply(ST_FOUND, best, 1'b1));
                    tag_m[best] = TAG_SENT;
                    tim_m[best] = c.now;
                end
            end
            default: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tag_m[i] != TAG_ERASABLE) n++;
                if (n == 0) expected_replies.push_back(bare_reply(ST_EMPTY));
                for (int i = 0; i < NSLOT; i++)
                    if (tag_m[i] != TAG_ERASABLE) begin
                        n--;
                        expected_replies.push_back(slot_reply(ST_ENTRY, i, n == 0));
                    end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    // Driver: a new word is loaded only after the previous one was taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) predict_mailbox(t_tb_cmd'(s_axis_tdata[137:0]));
            if (pending_cmds.size() > 0 && !sender_pause &&
                $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata <= {6'b0, pending_cmds.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver hold-off, counted here.
    always @(posedge i_clk) begin
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            recv_hold <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            recv_hold <= 1'b0;
        end
        if (!hold_req) hold_cnt <= 0;
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_tb_reply got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_tb_reply'({m_axis_tlast, m_axis_tdata[136:0]});
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected word", got.status, 0);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
                    if (got.etag !== want.etag) report_mismatch("tag", got.etag, want.etag);
                    if (got.erecipient !== want.erecipient)
                        report_mismatch("recipient", got.erecipient, want.erecipient);
                    if (got.esender !== want.esender)
                        report_mismatch("sender", got.esender, want.esender);
                    if (got.etime !== want.etime)
                        report_mismatch("time", got.etime, want.etime);
                    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
                end
            end
            m_axis_tready <= !recv_hold && $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || recv_hold
            || (pending_cmds.size() == 0 && expected_replies.size() == 0 && !s_axis_tvalid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("message_slot_table_core verification failed");
            $finish;
        end
    end

    function automatic logic [47:0] pick_call();
        case ($urandom_range(4))
            0: return 48'h0;
            1: return 48'hFFFF_FFFF_FFFF;
            default: return 48'h4E30_0000_0000 + $urandom_range(5);
        endcase
    endfunction

    function automatic t_tb_cmd make_cmd(logic [1:0] k, logic [31:0] t, logic [47:0] s,
                                         logic [47:0] r, logic [7:0] len);
        t_tb_cmd c;
        c.kind = k;
        c.now = t;
        c.sender = s;
        c.recipient = r;
        c.length = len;
        return c;
    endfunction

    task automatic wait_drain();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SENT_EXP: sent_exp_m = val;
            CFG_UNSENT_EXP: unsent_exp_m = val;
            CFG_QUOTA: quota_m = val[4:0];
            default: maxlen_m = val[7:0];
        endcase
    endtask

    task automatic random_burst(int count, logic [31:0] base);
        logic [31:0] t;
        logic [1:0] k;
        t = base;
        for (int n = 0; n < count; n++) begin
            t = t + $urandom_range(50000);
            k = ($urandom_range(9) < 4) ? KIND_STORE : 2'($urandom_range(3));
            if ($urandom_range(19) == 0) t = $urandom;
            pending_cmds.push_back(make_cmd(k, t, pick_call(), pick_call(),
                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(200))));
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tag_m[i] = TAG_ERASABLE;
            rcp_m[i] = '0;
            snd_m[i] = '0;
            tim_m[i] = '0;
        end
        live_m = 0;
        sent_exp_m = 86400;
        unsent_exp_m = 604800;
        quota_m = 4;
        maxlen_m = 200;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_cmds.push_back(make_cmd(KIND_LIST, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_ASK, 5, 48'hFFFF_FFFF_FFFF, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_STORE, 10, 48'hA, 48'hB, 200));
        pending_cmds.push_back(make_cmd(KIND_STORE, 10, 48'hA, 48'hB, 201));
        pending_cmds.push_back(make_cmd(KIND_STORE, 9, 48'hC, 48'hB, 0));
        pending_cmds.push_back(make_cmd(KIND_STORE, 9, 48'hFFFF_FFFF_FFFF,
                                        48'hFFFF_FFFF_FFFF, 255));
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(make_cmd(KIND_STORE, 20, 48'hD, 48'hE, 8'(i)));
        pending_cmds.push_back(make_cmd(KIND_ASK, 30, 48'hB, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_ASK, 31, 48'hB, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_LIST, 40, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_SWEEP, 32'hFFFF_FFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_LIST, 0, 0, 0, 0));
        wait_drain();

        write_reg(CFG_QUOTA, 16);
        write_reg(CFG_MAXLEN, 255);
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(make_cmd(KIND_STORE, 32'(i), 48'h7, 48'(i), 8'hFF));
        pending_cmds.push_back(make_cmd(KIND_LIST, 100, 0, 0, 0));
        hold_req = 1;
        wait (hold_cnt >= HOLD_CYCLES);
        hold_req = 0;
        wait_drain();

        write_reg(CFG_SENT_EXP, 0);
        write_reg(CFG_UNSENT_EXP, 32'hFFFF_FFFF);
        pending_cmds.push_back(make_cmd(KIND_ASK, 50, 48'h3, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_SWEEP, 60, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_LIST, 60, 0, 0, 0));
        wait_drain();
        write_reg(CFG_UNSENT_EXP, 0);
        pending_cmds.push_back(make_cmd(KIND_SWEEP, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_LIST, 0, 0, 0, 0));
        wait_drain();

        write_reg(CFG_QUOTA, 0);
        write_reg(CFG_MAXLEN, 0);
        pending_cmds.push_back(make_cmd(KIND_STORE, 1, 48'h1, 48'h2, 0));
        wait_drain();

        write_reg(CFG_SENT_EXP, 200000);
        write_reg(CFG_UNSENT_EXP, 400000);
        write_reg(CFG_QUOTA, 1);
        write_reg(CFG_MAXLEN, 128);
        random_burst(50, 0);
        wait_drain();

        write_reg(CFG_QUOTA, 4);
        write_reg(CFG_MAXLEN, 200);
        write_reg(CFG_SENT_EXP, 86400);
        write_reg(CFG_UNSENT_EXP, 604800);
        send_idle_pct = 70;
        random_burst(50, 32'h8000_0000);
        wait_drain();
        send_idle_pct = 0;
        recv_stall_pct = 70;
        random_burst(50, 32'hFFF0_0000);
        repeat (100) @(posedge i_clk);
        sender_pause = 1;
        while (s_axis_tvalid || expected_replies.size() > 0)
            @(posedge i_clk);
        sender_pause = 0;
        wait_drain();
        send_idle_pct = 29;
        recv_stall_pct = 29;
        write_reg(CFG_QUOTA, 16);
        random_burst(50, 1000);
        wait_drain();

        if (fail_count == 0) begin
            $display("message_slot_table_core verification clean");
        end else begin
            $display("message_slot_table_core verification failed");
        end
        $finish;
    end
endmodule
